FILE: design/dhot_pkg.sv
// ----------------------------------------------------------------------------
// dhot_pkg: shared types and constants
// Widths, command codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package dhot_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned KEY_W    = 31;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned SIZE_W   = 5;
  localparam int unsigned MOD_W    = 16;
  localparam int unsigned HOME_W   = 4;
  localparam int unsigned VAC_W    = 5;

  typedef enum logic [1:0] {
    CMD_PUT    = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_ERASE  = 2'd2,
    CMD_VACANT = 2'd3
  } cmd_t;

  localparam logic CFG_SIZE = 1'b0;
  localparam logic CFG_MOD  = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture item, start key reductions
    logic red_step;  // one bit of the key reductions or of the step reduction
    logic red_init;  // latch step and init probe position
    logic rd;        // issue slot read at probe position
    logic adv;       // advance probe position
    logic wr_put;    // write key/payload, mark used
    logic clr;       // clear used bit (erase)
    logic hit_cap;   // flag hit, select found slot for result
    logic emit;      // drive result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic red_done;
    logic slot_used;
    logic key_match;
    logic last_probe;
    cmd_t cmd;
  } dp_sts_t;

endpackage

FILE: design/dhot_ram.sv
// ----------------------------------------------------------------------------
// dhot_ram: generic single-port RAM
// One registered read per cycle, plus a write when we is set (read-first).
// ----------------------------------------------------------------------------
module dhot_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: design/dhot_dp.sv
// ----------------------------------------------------------------------------
// dhot_dp: datapath
// Serial modulo reductions, probe position walk, slot store and result regs.
// ----------------------------------------------------------------------------
module dhot_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_sel,
  input  logic [dhot_pkg::MOD_W-1:0]  cfg_data,
  input  logic [1:0]                  in_cmd,
  input  logic [dhot_pkg::KEY_W-1:0]  in_key,
  input  logic [dhot_pkg::VAL_W-1:0]  in_value,
  input  dhot_pkg::dp_cmd_t           dc,
  output dhot_pkg::dp_sts_t           ds,
  output logic [3:0]                  out_home_slot,
  output logic [3:0]                  out_slot_index,
  output logic [31:0]                 out_found_value,
  output logic [4:0]                  out_vacant_count
);

  localparam int unsigned IW = dhot_pkg::IDX_W;
  localparam int unsigned CW = dhot_pkg::CNT_W;
  localparam int unsigned MW = dhot_pkg::MOD_W;
  localparam int unsigned KW = dhot_pkg::KEY_W;
  localparam int unsigned CAPACITY_L = dhot_pkg::CAPACITY;

  logic [dhot_pkg::SIZE_W-1:0] size_cfg_r;
  logic [MW-1:0]               mod_cfg_r;
  logic [CW-1:0]               size_eff;
  logic [MW-1:0]               mod_eff;

  logic [1:0]    cmd_r;
  logic [KW-1:0] key_r;
  logic [dhot_pkg::VAL_W-1:0] val_r;
  logic [KW-1:0] shf_r;
  logic [4:0]    bit_r;
  logic [CW-1:0] hrem_r, hrem_nxt;
  logic [MW-1:0] mrem_r, mrem_nxt;
  logic          red_done_r;
  logic [CW-1:0] step_r;
  logic [IW-1:0] pos_r;
  logic [CW-1:0] cnt_r;
  logic [IW-1:0] rd_addr_r;
  logic [CAPACITY_L-1:0] used_r;
  logic [CW-1:0] occ_r;
  logic          rd_used_r;

  logic [KW-1:0]              key_q;
  logic [dhot_pkg::VAL_W-1:0] pay_q;
  logic [CW:0]                hr_sh;
  logic [MW:0]                mr_sh;
  logic [MW:0]                step_full;
  logic [CW:0]                step_red;
  logic [CW:0]                pos_sum;
  logic                       we;
  logic [IW-1:0]              addr;

  always_comb begin
    size_eff = (size_cfg_r == '0) ? CW'(1) :
               ((CW'(size_cfg_r) > CW'(CAPACITY_L)) ? CW'(CAPACITY_L) : CW'(size_cfg_r));
    mod_eff  = (mod_cfg_r == '0) ? MW'(1) : mod_cfg_r;
  end

  // one restoring-division bit per red_step cycle for both key remainders
  always_comb begin
    hr_sh    = {hrem_r, shf_r[KW-1]};
    mr_sh    = {mrem_r, shf_r[KW-1]};
    hrem_nxt = (hr_sh >= {1'b0, size_eff}) ? CW'(hr_sh - {1'b0, size_eff}) : CW'(hr_sh);
    mrem_nxt = (mr_sh >= {1'b0, mod_eff}) ? MW'(mr_sh - {1'b0, mod_eff}) : MW'(mr_sh);
    step_full = {1'b0, mod_eff} - {1'b0, mrem_nxt};
    pos_sum   = {1'b0, CW'(pos_r)} + {1'b0, step_r};
  end

  // step mod size, one bit per red_step cycle after the key reductions
  logic [4:0]    sbit_r;
  logic [CW-1:0] srem_r, srem_nxt;
  logic [MW-1:0] sshf_r;
  logic [CW:0]   sr_sh;
  logic          s_busy_r;

  always_comb begin
    sr_sh    = {srem_r, sshf_r[MW-1]};
    srem_nxt = (sr_sh >= {1'b0, size_eff}) ? CW'(sr_sh - {1'b0, size_eff}) : CW'(sr_sh);
    step_red = {1'b0, srem_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_cfg_r <= 5'd16;
      mod_cfg_r  <= 16'd13;
      used_r     <= '0;
      occ_r      <= '0;
      red_done_r <= 1'b0;
      s_busy_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_sel == dhot_pkg::CFG_SIZE) size_cfg_r <= cfg_data[dhot_pkg::SIZE_W-1:0];
        else                               mod_cfg_r  <= cfg_data;
      end
      if (dc.load) begin
        red_done_r <= 1'b0;
        s_busy_r   <= 1'b0;
      end else if (dc.red_step) begin
        if (!s_busy_r) begin
          if (bit_r == 5'd0) begin
            s_busy_r <= 1'b1;
          end
        end else if (sbit_r == 5'd0) begin
          red_done_r <= 1'b1;
        end
      end
      if (dc.wr_put) begin
        used_r[pos_r] <= 1'b1;
        occ_r         <= occ_r + CW'(1);
      end
      if (dc.clr) begin
        used_r[rd_addr_r] <= 1'b0;
        if (occ_r != '0) occ_r <= occ_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dc.load) begin
      cmd_r  <= in_cmd;
      key_r  <= in_key;
      val_r  <= in_value;
      shf_r  <= in_key;
      bit_r  <= 5'(KW - 1);
      hrem_r <= '0;
      mrem_r <= '0;
    end else if (dc.red_step) begin
      if (!s_busy_r) begin
        shf_r  <= {shf_r[KW-2:0], 1'b0};
        hrem_r <= hrem_nxt;
        mrem_r <= mrem_nxt;
        bit_r  <= bit_r - 5'd1;
        sshf_r <= MW'(step_full);
        srem_r <= '0;
        sbit_r <= 5'(MW - 1);
      end else begin
        sshf_r <= {sshf_r[MW-2:0], 1'b0};
        srem_r <= srem_nxt;
        sbit_r <= sbit_r - 5'd1;
      end
    end
    if (dc.red_init) begin
      step_r <= CW'(step_red);
      pos_r  <= IW'(hrem_r);
      cnt_r  <= '0;
    end
    if (dc.adv) begin
      pos_r <= (pos_sum >= {1'b0, size_eff}) ? IW'(pos_sum - {1'b0, size_eff})
                                             : IW'(pos_sum);
      cnt_r <= cnt_r + CW'(1);
    end
    if (dc.rd) begin
      rd_addr_r <= pos_r;
      rd_used_r <= used_r[pos_r];
    end
  end

  assign we   = dc.wr_put;
  assign addr = dc.wr_put ? pos_r : pos_r;

  dhot_ram #(.WIDTH(KW), .DEPTH(CAPACITY_L)) u_key (
    .clk(clk), .we(we), .addr(addr), .wdata(key_r), .rdata(key_q)
  );
  dhot_ram #(.WIDTH(dhot_pkg::VAL_W), .DEPTH(CAPACITY_L)) u_pay (
    .clk(clk), .we(we), .addr(addr), .wdata(val_r), .rdata(pay_q)
  );

  always_comb begin
    ds.red_done   = red_done_r;
    ds.slot_used  = rd_used_r;
    ds.key_match  = (key_q == key_r);
    ds.last_probe = (cnt_r == size_eff - CW'(1));
    ds.cmd        = dhot_pkg::cmd_t'(cmd_r);
  end

  logic [CW-1:0] vac;
  assign vac = (size_eff > occ_r) ? (size_eff - occ_r) : '0;

  logic [3:0]  home_nxt;
  logic [3:0]  slot_nxt;
  logic [31:0] fval_nxt;
  logic [4:0]  vac_nxt;

  always_comb begin
    home_nxt = '0;
    slot_nxt = '0;
    fval_nxt = '0;
    vac_nxt  = '0;
    unique case (dhot_pkg::cmd_t'(cmd_r))
      dhot_pkg::CMD_PUT: begin
        home_nxt = 4'(hrem_r);
        slot_nxt = dc.hit_cap ? 4'(rd_addr_r) : '0;
      end
      dhot_pkg::CMD_FIND, dhot_pkg::CMD_ERASE: begin
        slot_nxt = dc.hit_cap ? 4'(rd_addr_r) : '0;
        fval_nxt = dc.hit_cap ? pay_q : '0;
      end
      dhot_pkg::CMD_VACANT: begin
        vac_nxt = 5'(vac);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (dc.emit) begin
      out_home_slot    <= home_nxt;
      out_slot_index   <= slot_nxt;
      out_found_value  <= fval_nxt;
      out_vacant_count <= vac_nxt;
    end
  end

endmodule

FILE: design/dhot_ctrl.sv
// ----------------------------------------------------------------------------
// dhot_ctrl: controller
// Sequences key reduction, probe walk, slot update and result strobe.
// ----------------------------------------------------------------------------
module dhot_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  dhot_pkg::dp_sts_t ds,
  output dhot_pkg::dp_cmd_t dc,
  output logic              done,
  output logic              fail
);

  typedef enum logic [2:0] {S_IDLE, S_RED, S_INIT, S_RD, S_CHK, S_EMIT} state_t;

  state_t state_r;
  logic   done_r, fail_r, busy_r, hit_r;

  always_comb begin
    dc = '0;
    dc.load     = (state_r == S_IDLE) && start;
    dc.red_step = (state_r == S_RED) && !ds.red_done;
    dc.red_init = (state_r == S_RED) && ds.red_done;
    dc.rd       = (state_r == S_RD);
    if (state_r == S_CHK) begin
      if (ds.cmd == dhot_pkg::CMD_PUT) begin
        if (!ds.slot_used) begin
          dc.wr_put  = 1'b1;
          dc.hit_cap = 1'b1;
          dc.emit    = 1'b1;
        end else begin
          dc.adv  = 1'b1;
          dc.emit = ds.last_probe;
        end
      end else if (ds.slot_used && ds.key_match) begin
        dc.hit_cap = 1'b1;
        dc.clr     = (ds.cmd == dhot_pkg::CMD_ERASE);
        dc.emit    = 1'b1;
      end else begin
        dc.adv  = 1'b1;
        dc.emit = ds.last_probe;
      end
    end
    if (state_r == S_EMIT) dc.emit = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
      fail_r  <= 1'b0;
      busy_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (start) begin
          state_r <= S_RED;
          busy_r  <= 1'b1;
        end
        S_RED: if (ds.red_done) begin
          state_r <= (ds.cmd == dhot_pkg::CMD_VACANT) ? S_EMIT : S_RD;
        end
        S_INIT: state_r <= S_RD;
        S_RD: state_r <= S_CHK;
        S_CHK: if (dc.emit) begin
          state_r <= S_IDLE;
          done_r  <= 1'b1;
          fail_r  <= !dc.hit_cap;
          busy_r  <= 1'b0;
        end else begin
          state_r <= S_RD;
        end
        S_EMIT: begin
          state_r <= S_IDLE;
          done_r  <= 1'b1;
          fail_r  <= 1'b0;
          busy_r  <= 1'b0;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign hit_r = 1'b0;
  assign busy  = busy_r | hit_r;
  assign done  = done_r;
  assign fail  = fail_r;

endmodule

FILE: design/double_hash_open_address_table_unit.sv
// ----------------------------------------------------------------------------
// double_hash_open_address_table_unit: double-hashing open-address table
// Serial key and step reductions, then a slot read and a check per probe
// until a hit or the last probe, then the result strobe. One command in
// flight at a time. Throughput set by the serial modulo units and the one-port
// slot store. Sync reset clears used flags, count and config to 16 / 13.
// ----------------------------------------------------------------------------
module double_hash_open_address_table_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [30:0] in_key,
  input  logic [31:0] in_value,
  output logic        out_strobe,
  output logic        out_status,
  output logic [3:0]  out_home_slot,
  output logic [3:0]  out_slot_index,
  output logic [31:0] out_found_value,
  output logic [4:0]  out_vacant_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  dhot_pkg::dp_cmd_t dc;
  dhot_pkg::dp_sts_t ds;
  logic done, fail;

  assign cfg_ready = 1'b1;

  dhot_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .ds(ds), .dc(dc), .done(done), .fail(fail)
  );

  dhot_dp u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_valid & cfg_ready), .cfg_sel(cfg_index), .cfg_data(cfg_data),
    .in_cmd(in_cmd), .in_key(in_key), .in_value(in_value),
    .dc(dc), .ds(ds),
    .out_home_slot(out_home_slot),
    .out_slot_index(out_slot_index), .out_found_value(out_found_value),
    .out_vacant_count(out_vacant_count)
  );

  assign out_strobe = done;
  assign out_status = fail;

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy) else $error("strobe while busy");
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy not raised");
  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("double strobe");

endmodule
